[rtl/mlpbp_pkg.sv]
// ----------------------------------------------------------------------------
// mlpbp_pkg: shared types, codes and arithmetic helpers
// Types, request codes, register indexes, sequencer states and the Q4.12
// rounding and saturation helpers of the layer gradient engine.
// ----------------------------------------------------------------------------
`default_nettype none

package mlpbp_pkg;

   // Default store dimensions
   localparam int DEF_BATCH_MAX = 16;
   localparam int DEF_CUR_MAX   = 16;
   localparam int DEF_NEXT_MAX  = 16;
   localparam int DEF_PREV_MAX  = 16;

   // Dimension registers and loop counters hold values up to 127
   localparam int CNT_W = 7;
   // Accumulator and product widths
   localparam int ACC_W  = 40;
   localparam int MUL_W  = 18;
   localparam int PROD_W = 2 * MUL_W;

   // Configuration register indexes
   localparam logic [2:0] CSR_MODE  = 3'd0;
   localparam logic [2:0] CSR_BATCH = 3'd1;
   localparam logic [2:0] CSR_CUR   = 3'd2;
   localparam logic [2:0] CSR_NEXT  = 3'd3;
   localparam logic [2:0] CSR_PREV  = 3'd4;

   // Request codes
   typedef enum logic [3:0] {
      REQ_LOAD_W     = 4'd0,
      REQ_LOAD_DNEXT = 4'd1,
      REQ_LOAD_A     = 4'd2,
      REQ_LOAD_T     = 4'd3,
      REQ_LOAD_PREVA = 4'd4,
      REQ_COMPUTE    = 4'd5,
      REQ_READ_DELTA = 4'd6,
      REQ_READ_DB    = 4'd7,
      REQ_READ_DW    = 4'd8
   } req_code_type;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_D_CELL,
      ST_O_SUB,
      ST_H_RD,
      ST_H_MUL,
      ST_H_ACC,
      ST_H_ERR,
      ST_H_DER,
      ST_H_FIN1,
      ST_H_FIN2,
      ST_B_RD,
      ST_B_ACC,
      ST_B_WR,
      ST_W_RD,
      ST_W_MUL
   } state_type;

   // Payloads
   typedef struct packed {
      logic [3:0]         req_type;
      logic [5:0]         row_index;
      logic [5:0]         col_index;
      logic signed [15:0] load_value;
   } req_payload_type;

   typedef struct packed {
      logic signed [15:0] read_value;
      logic               read_status;
   } rsp_payload_type;

   // Round half up to Q4.12: add half an LSB, then floor by arithmetic shift.
   function automatic logic signed [ACC_W-1:0] round_q12(input logic signed [ACC_W-1:0] x);
      logic signed [ACC_W-1:0] y;
      begin
         y = x + 40'sd2048;
         return y >>> 12;
      end
   endfunction

   // Saturate to the signed 16-bit range.
   function automatic logic signed [15:0] sat16(input logic signed [ACC_W-1:0] x);
      begin
         if (x > 40'sd32767) begin
            return 16'sh7FFF;
         end else if (x < -40'sd32768) begin
            return 16'sh8000;
         end
         return x[15:0];
      end
   endfunction

endpackage

`default_nettype wire

[rtl/mlp_layer_backprop_gradients_top.sv]
// ----------------------------------------------------------------------------
// mlp_layer_backprop_gradients_top: backward pass of one dense sigmoid layer
// Stores layer operands, computes delta, bias gradients and weight gradients
// in Q4.12 with one shared multiply-accumulate unit, and serves reads.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel (req_valid, req_stall, req_data) carries load, compute
//   and read items; a transfer happens when req_valid is high and req_stall is
//   low. Only read items produce a response on rsp_valid / rsp_data, which is
//   held until a cycle with rsp_stall low. Dimension and mode registers are
//   written through csr_valid / csr_ready / csr_index / csr_wdata; the user must
//   write them only while idle, which the block does not enforce. A load is
//   stored when it transfers; a read goes through the read state and the
//   response register. A compute item runs a sequencer over the stores with
//   one 18x18 multiplier and a 40-bit accumulator: delta over BATCH_MAX*CUR_MAX
//   cells (output or hidden mode, unused cells zero), db over CUR_MAX columns
//   and dW over PREV_MAX*CUR_MAX cells; the request channel is stalled
//   throughout. A pending response that is being stalled also stalls the
//   request channel.
//   Synchronous reset clears the registers to mode 0 and all sizes 16, and
//   marks results as not computed; store contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module mlp_layer_backprop_gradients_top #(
   parameter int BATCH_MAX = mlpbp_pkg::DEF_BATCH_MAX,
   parameter int CUR_MAX   = mlpbp_pkg::DEF_CUR_MAX,
   parameter int NEXT_MAX  = mlpbp_pkg::DEF_NEXT_MAX,
   parameter int PREV_MAX  = mlpbp_pkg::DEF_PREV_MAX
) (
   input  wire                         clock,
   input  wire                         reset,
   // Request channel
   input  wire                         req_valid,
   output logic                        req_stall,
   input  mlpbp_pkg::req_payload_type  req_data,
   // Response channel
   output logic                        rsp_valid,
   input  wire                         rsp_stall,
   output mlpbp_pkg::rsp_payload_type  rsp_data,
   // Register write port
   input  wire                         csr_valid,
   output logic                        csr_ready,
   input  wire  [2:0]                  csr_index,
   input  wire  [6:0]                  csr_wdata
);

   localparam int CW = mlpbp_pkg::CNT_W;
   localparam int AW = mlpbp_pkg::ACC_W;
   localparam int PW = mlpbp_pkg::PROD_W;
   localparam int MW = mlpbp_pkg::MUL_W;

   localparam int W_D  = CUR_MAX * NEXT_MAX;
   localparam int DN_D = BATCH_MAX * NEXT_MAX;
   localparam int A_D  = BATCH_MAX * CUR_MAX;
   localparam int PA_D = BATCH_MAX * PREV_MAX;
   localparam int G_D  = PREV_MAX * CUR_MAX;
   localparam int W_AW  = (W_D > 1) ? $clog2(W_D) : 1;
   localparam int DN_AW = (DN_D > 1) ? $clog2(DN_D) : 1;
   localparam int A_AW  = (A_D > 1) ? $clog2(A_D) : 1;
   localparam int PA_AW = (PA_D > 1) ? $clog2(PA_D) : 1;
   localparam int G_AW  = (G_D > 1) ? $clog2(G_D) : 1;
   localparam int B_AW  = (CUR_MAX > 1) ? $clog2(CUR_MAX) : 1;

   localparam logic [CW-1:0] BATCH_LAST = CW'(BATCH_MAX - 1);
   localparam logic [CW-1:0] CUR_LAST   = CW'(CUR_MAX - 1);
   localparam logic [CW-1:0] PREV_LAST  = CW'(PREV_MAX - 1);

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   mlpbp_pkg::state_type       state_ff, state_in;
   logic                       mode_ff;
   logic [CW-1:0]              nb_cfg_ff, nc_cfg_ff, nn_cfg_ff, np_cfg_ff;
   logic [CW-1:0]              i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic signed [AW-1:0]       acc_ff, acc_in;
   logic signed [PW-1:0]       prod_ff;
   logic signed [15:0]         err_ff, err_in, der_ff, der_in;
   logic                       ready_ff, ready_in;
   mlpbp_pkg::req_code_type    rd_kind_ff, rd_kind_in;
   logic                       rd_ok_ff, rd_ok_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   mlpbp_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;

   // Stores and their registered read data
   logic signed [15:0] w_mem  [W_D];
   logic signed [15:0] dn_mem [DN_D];
   logic signed [15:0] a_mem  [A_D];
   logic signed [15:0] t_mem  [A_D];
   logic signed [15:0] pa_mem [PA_D];
   logic signed [15:0] d_mem  [A_D];
   logic signed [15:0] b_mem  [CUR_MAX];
   logic signed [15:0] g_mem  [G_D];
   logic signed [15:0] w_q_ff, dn_q_ff, a_q_ff, t_q_ff, pa_q_ff, d_q_ff, b_q_ff, g_q_ff;

   // ------------------------------------------------------------------
   // Handshakes and effective dimensions
   // ------------------------------------------------------------------
   logic                    req_accept;
   mlpbp_pkg::req_code_type req_code;
   logic [CW-1:0]           req_row, req_col;
   logic [CW-1:0]           nb, nc, nn, np;

   assign req_stall  = (state_ff != mlpbp_pkg::ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_accept = req_valid && !req_stall;
   assign req_code   = mlpbp_pkg::req_code_type'(req_data.req_type);
   assign req_row    = {1'b0, req_data.row_index};
   assign req_col    = {1'b0, req_data.col_index};
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // A register value above the store bound acts as the bound.
   assign nb = (nb_cfg_ff > CW'(BATCH_MAX)) ? CW'(BATCH_MAX) : nb_cfg_ff;
   assign nc = (nc_cfg_ff > CW'(CUR_MAX))   ? CW'(CUR_MAX)   : nc_cfg_ff;
   assign nn = (nn_cfg_ff > CW'(NEXT_MAX))  ? CW'(NEXT_MAX)  : nn_cfg_ff;
   assign np = (np_cfg_ff > CW'(PREV_MAX))  ? CW'(PREV_MAX)  : np_cfg_ff;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= 1'b0;
         nb_cfg_ff <= 7'd16;
         nc_cfg_ff <= 7'd16;
         nn_cfg_ff <= 7'd16;
         np_cfg_ff <= 7'd16;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            mlpbp_pkg::CSR_MODE:  mode_ff   <= csr_wdata[0];
            mlpbp_pkg::CSR_BATCH: nb_cfg_ff <= csr_wdata;
            mlpbp_pkg::CSR_CUR:   nc_cfg_ff <= csr_wdata;
            mlpbp_pkg::CSR_NEXT:  nn_cfg_ff <= csr_wdata;
            mlpbp_pkg::CSR_PREV:  np_cfg_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Condition flags for the sequencer
   // ------------------------------------------------------------------
   logic cell_used, d_last, b_more, w_more, h_more, w_last;

   assign cell_used = (i_ff < nb) && (j_ff < nc);
   assign d_last    = (i_ff == BATCH_LAST) && (j_ff == CUR_LAST);
   assign h_more    = (k_ff < nn);
   assign b_more    = (j_ff < nc) && (k_ff < nb);
   assign w_more    = (i_ff < np) && (j_ff < nc) && (k_ff < nb);
   assign w_last    = (i_ff == PREV_LAST) && (j_ff == CUR_LAST);

   // ------------------------------------------------------------------
   // Next state
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mlpbp_pkg::ST_IDLE: begin
            if (req_accept) begin
               case (req_code)
                  mlpbp_pkg::REQ_COMPUTE:    state_in = mlpbp_pkg::ST_D_CELL;
                  mlpbp_pkg::REQ_READ_DELTA,
                  mlpbp_pkg::REQ_READ_DB,
                  mlpbp_pkg::REQ_READ_DW:    state_in = mlpbp_pkg::ST_READ;
                  default:                   state_in = mlpbp_pkg::ST_IDLE;
               endcase
            end
         end
         mlpbp_pkg::ST_READ: state_in = mlpbp_pkg::ST_IDLE;
         mlpbp_pkg::ST_D_CELL: begin
            if (!cell_used) begin
               state_in = d_last ? mlpbp_pkg::ST_B_RD : mlpbp_pkg::ST_D_CELL;
            end else if (mode_ff) begin
               state_in = mlpbp_pkg::ST_O_SUB;
            end else begin
               state_in = mlpbp_pkg::ST_H_RD;
            end
         end
         mlpbp_pkg::ST_O_SUB,
         mlpbp_pkg::ST_H_FIN2: begin
            state_in = d_last ? mlpbp_pkg::ST_B_RD : mlpbp_pkg::ST_D_CELL;
         end
         mlpbp_pkg::ST_H_RD:   state_in = h_more ? mlpbp_pkg::ST_H_MUL : mlpbp_pkg::ST_H_ERR;
         mlpbp_pkg::ST_H_MUL:  state_in = mlpbp_pkg::ST_H_ACC;
         mlpbp_pkg::ST_H_ACC:  state_in = mlpbp_pkg::ST_H_RD;
         mlpbp_pkg::ST_H_ERR:  state_in = mlpbp_pkg::ST_H_DER;
         mlpbp_pkg::ST_H_DER:  state_in = mlpbp_pkg::ST_H_FIN1;
         mlpbp_pkg::ST_H_FIN1: state_in = mlpbp_pkg::ST_H_FIN2;
         mlpbp_pkg::ST_B_RD:   state_in = b_more ? mlpbp_pkg::ST_B_ACC : mlpbp_pkg::ST_B_WR;
         mlpbp_pkg::ST_B_ACC:  state_in = mlpbp_pkg::ST_B_RD;
         mlpbp_pkg::ST_B_WR: begin
            state_in = (j_ff == CUR_LAST) ? mlpbp_pkg::ST_W_RD : mlpbp_pkg::ST_B_RD;
         end
         mlpbp_pkg::ST_W_RD: begin
            if (w_more) begin
               state_in = mlpbp_pkg::ST_W_MUL;
            end else begin
               state_in = w_last ? mlpbp_pkg::ST_IDLE : mlpbp_pkg::ST_W_RD;
            end
         end
         // The dW accumulate step folds into the read state of the next term.
         mlpbp_pkg::ST_W_MUL:  state_in = mlpbp_pkg::ST_W_RD;
         default:              state_in = mlpbp_pkg::ST_IDLE;
      endcase
   end

   // ------------------------------------------------------------------
   // Datapath controls: store addresses, write enables, multiplier operands
   // ------------------------------------------------------------------
   logic [W_AW-1:0]      w_waddr, w_raddr;
   logic [DN_AW-1:0]     dn_waddr, dn_raddr;
   logic [A_AW-1:0]      a_waddr, a_raddr, d_waddr, d_raddr;
   logic [PA_AW-1:0]     pa_waddr, pa_raddr;
   logic [B_AW-1:0]      b_waddr, b_raddr;
   logic [G_AW-1:0]      g_waddr, g_raddr;
   logic                 w_we, dn_we, a_we, t_we, pa_we, d_we, b_we, g_we;
   logic signed [15:0]   d_wdata, b_wdata, g_wdata;
   logic signed [MW-1:0] mul_a, mul_b;
   logic                 req_is_load;
   logic                 w_mac_step;

   // The product formed in the multiply state is accumulated in the following read
   // state, while the next operands are read; this flag marks the dW read states that follow a product.
   logic w_pend_ff, w_pend_in;

   always_comb begin
      req_is_load = req_accept && (state_ff == mlpbp_pkg::ST_IDLE);
      // Load addresses
      w_waddr  = W_AW'(int'(req_row) * NEXT_MAX + int'(req_col));
      dn_waddr = DN_AW'(int'(req_row) * NEXT_MAX + int'(req_col));
      a_waddr  = A_AW'(int'(req_row) * CUR_MAX + int'(req_col));
      pa_waddr = PA_AW'(int'(req_row) * PREV_MAX + int'(req_col));
      w_we  = req_is_load && (req_code == mlpbp_pkg::REQ_LOAD_W)
              && (req_row < CW'(CUR_MAX)) && (req_col < CW'(NEXT_MAX));
      dn_we = req_is_load && (req_code == mlpbp_pkg::REQ_LOAD_DNEXT)
              && (req_row < CW'(BATCH_MAX)) && (req_col < CW'(NEXT_MAX));
      a_we  = req_is_load && (req_code == mlpbp_pkg::REQ_LOAD_A)
              && (req_row < CW'(BATCH_MAX)) && (req_col < CW'(CUR_MAX));
      t_we  = req_is_load && (req_code == mlpbp_pkg::REQ_LOAD_T)
              && (req_row < CW'(BATCH_MAX)) && (req_col < CW'(CUR_MAX));
      pa_we = req_is_load && (req_code == mlpbp_pkg::REQ_LOAD_PREVA)
              && (req_row < CW'(BATCH_MAX)) && (req_col < CW'(PREV_MAX));

      // Sequencer read addresses
      w_raddr  = W_AW'(int'(j_ff) * NEXT_MAX + int'(k_ff));
      dn_raddr = DN_AW'(int'(i_ff) * NEXT_MAX + int'(k_ff));
      a_raddr  = A_AW'(int'(i_ff) * CUR_MAX + int'(j_ff));
      pa_raddr = PA_AW'(int'(k_ff) * PREV_MAX + int'(i_ff));
      if (state_ff == mlpbp_pkg::ST_IDLE) begin
         d_raddr = A_AW'(int'(req_row) * CUR_MAX + int'(req_col));
      end else begin
         d_raddr = A_AW'(int'(k_ff) * CUR_MAX + int'(j_ff));
      end
      b_raddr = B_AW'(req_row);
      g_raddr = G_AW'(int'(req_row) * CUR_MAX + int'(req_col));

      // Result writes
      d_waddr = a_raddr;
      b_waddr = B_AW'(j_ff);
      g_waddr = G_AW'(int'(i_ff) * CUR_MAX + int'(j_ff));
      d_we    = 1'b0;
      d_wdata = '0;
      case (state_ff)
         mlpbp_pkg::ST_D_CELL: d_we = !cell_used;
         mlpbp_pkg::ST_O_SUB: begin
            d_we    = 1'b1;
            d_wdata = mlpbp_pkg::sat16(AW'(a_q_ff) - AW'(t_q_ff));
         end
         mlpbp_pkg::ST_H_FIN2: begin
            d_we    = 1'b1;
            d_wdata = mlpbp_pkg::sat16(mlpbp_pkg::round_q12(AW'(prod_ff)));
         end
         default: ;
      endcase
      b_we    = (state_ff == mlpbp_pkg::ST_B_WR);
      b_wdata = mlpbp_pkg::sat16(acc_ff);
      w_mac_step = (state_ff == mlpbp_pkg::ST_W_RD) && w_pend_ff;
      g_we    = (state_ff == mlpbp_pkg::ST_W_RD) && !w_more;
      g_wdata = mlpbp_pkg::sat16(mlpbp_pkg::round_q12(
                   w_mac_step ? acc_ff + AW'(prod_ff) : acc_ff));

      // Shared multiplier operands
      case (state_ff)
         mlpbp_pkg::ST_H_MUL: begin
            mul_a = MW'(dn_q_ff);
            mul_b = MW'(w_q_ff);
         end
         mlpbp_pkg::ST_H_ERR: begin
            mul_a = MW'(a_q_ff);
            mul_b = 18'sd4096 - MW'(a_q_ff);
         end
         mlpbp_pkg::ST_H_FIN1: begin
            mul_a = MW'(err_ff);
            mul_b = MW'(der_ff);
         end
         mlpbp_pkg::ST_W_MUL: begin
            mul_a = MW'(pa_q_ff);
            mul_b = MW'(d_q_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Counters, accumulator and response next values
   // ------------------------------------------------------------------
   always_comb begin
      i_in       = i_ff;
      j_in       = j_ff;
      k_in       = k_ff;
      acc_in     = acc_ff;
      err_in     = err_ff;
      der_in     = der_ff;
      ready_in   = ready_ff;
      rd_kind_in = rd_kind_ff;
      rd_ok_in   = rd_ok_ff;
      w_pend_in  = 1'b0;
      case (state_ff)
         mlpbp_pkg::ST_IDLE: begin
            if (req_accept) begin
               i_in       = '0;
               j_in       = '0;
               k_in       = '0;
               acc_in     = '0;
               rd_kind_in = req_code;
               case (req_code)
                  mlpbp_pkg::REQ_READ_DELTA:
                     rd_ok_in = (req_row < CW'(BATCH_MAX)) && (req_col < CW'(CUR_MAX));
                  mlpbp_pkg::REQ_READ_DB:
                     rd_ok_in = (req_row < CW'(CUR_MAX));
                  mlpbp_pkg::REQ_READ_DW:
                     rd_ok_in = (req_row < CW'(PREV_MAX)) && (req_col < CW'(CUR_MAX));
                  default:
                     rd_ok_in = 1'b0;
               endcase
            end
         end
         // Delta cells: step column first, then row
         mlpbp_pkg::ST_D_CELL,
         mlpbp_pkg::ST_O_SUB,
         mlpbp_pkg::ST_H_FIN2: begin
            k_in   = '0;
            acc_in = '0;
            if ((state_ff != mlpbp_pkg::ST_D_CELL) || !cell_used) begin
               if (j_ff == CUR_LAST) begin
                  j_in = '0;
                  i_in = (i_ff == BATCH_LAST) ? '0 : i_ff + 7'd1;
               end else begin
                  j_in = j_ff + 7'd1;
               end
            end
         end
         mlpbp_pkg::ST_H_ACC: begin
            acc_in = acc_ff + AW'(prod_ff);
            k_in   = k_ff + 7'd1;
         end
         mlpbp_pkg::ST_H_ERR: err_in = mlpbp_pkg::sat16(mlpbp_pkg::round_q12(acc_ff));
         mlpbp_pkg::ST_H_DER: begin
            der_in = mlpbp_pkg::sat16(mlpbp_pkg::round_q12(AW'(prod_ff)));
         end
         // Bias gradients: column sums of delta
         mlpbp_pkg::ST_B_ACC: begin
            acc_in = acc_ff + AW'(d_q_ff);
            k_in   = k_ff + 7'd1;
         end
         mlpbp_pkg::ST_B_WR: begin
            acc_in = '0;
            k_in   = '0;
            i_in   = '0;
            j_in   = (j_ff == CUR_LAST) ? '0 : j_ff + 7'd1;
         end
         // Weight gradients: accumulate the previous product, then read on
         mlpbp_pkg::ST_W_RD: begin
            if (w_more) begin
               if (w_mac_step) begin
                  acc_in = acc_ff + AW'(prod_ff);
               end
            end else begin
               acc_in = '0;
               k_in   = '0;
               if (j_ff == CUR_LAST) begin
                  j_in = '0;
                  i_in = (i_ff == PREV_LAST) ? '0 : i_ff + 7'd1;
               end else begin
                  j_in = j_ff + 7'd1;
               end
               if (w_last) begin
                  ready_in = 1'b1;
               end
            end
         end
         mlpbp_pkg::ST_W_MUL: begin
            k_in      = k_ff + 7'd1;
            w_pend_in = 1'b1;
         end
         default: ;
      endcase

      // Response register
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (state_ff == mlpbp_pkg::ST_READ) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.read_status = !ready_ff;
         rsp_data_in.read_value  = '0;
         if (ready_ff && rd_ok_ff) begin
            case (rd_kind_ff)
               mlpbp_pkg::REQ_READ_DELTA: rsp_data_in.read_value = d_q_ff;
               mlpbp_pkg::REQ_READ_DB:    rsp_data_in.read_value = b_q_ff;
               mlpbp_pkg::REQ_READ_DW:    rsp_data_in.read_value = g_q_ff;
               default:                   rsp_data_in.read_value = '0;
            endcase
         end
      end
   end

   // ------------------------------------------------------------------
   // Control and datapath registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mlpbp_pkg::ST_IDLE;
         i_ff         <= '0;
         j_ff         <= '0;
         k_ff         <= '0;
         ready_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         w_pend_ff    <= 1'b0;
         rd_kind_ff   <= mlpbp_pkg::REQ_READ_DELTA;
         rd_ok_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         k_ff         <= k_in;
         ready_ff     <= ready_in;
         rsp_valid_ff <= rsp_valid_in;
         w_pend_ff    <= w_pend_in;
         rd_kind_ff   <= rd_kind_in;
         rd_ok_ff     <= rd_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      err_ff      <= err_in;
      der_ff      <= der_in;
      prod_ff     <= mul_a * mul_b;
      rsp_data_ff <= rsp_data_in;
   end

   // ------------------------------------------------------------------
   // Stores: one write and one registered read each per cycle
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (w_we) begin
         w_mem[w_waddr] <= req_data.load_value;
      end
      w_q_ff <= w_mem[w_raddr];
   end

   always_ff @(posedge clock) begin
      if (dn_we) begin
         dn_mem[dn_waddr] <= req_data.load_value;
      end
      dn_q_ff <= dn_mem[dn_raddr];
   end

   always_ff @(posedge clock) begin
      if (a_we) begin
         a_mem[a_waddr] <= req_data.load_value;
      end
      a_q_ff <= a_mem[a_raddr];
   end

   always_ff @(posedge clock) begin
      if (t_we) begin
         t_mem[a_waddr] <= req_data.load_value;
      end
      t_q_ff <= t_mem[a_raddr];
   end

   always_ff @(posedge clock) begin
      if (pa_we) begin
         pa_mem[pa_waddr] <= req_data.load_value;
      end
      pa_q_ff <= pa_mem[pa_raddr];
   end

   always_ff @(posedge clock) begin
      if (d_we) begin
         d_mem[d_waddr] <= d_wdata;
      end
      d_q_ff <= d_mem[d_raddr];
   end

   always_ff @(posedge clock) begin
      if (b_we) begin
         b_mem[b_waddr] <= b_wdata;
      end
      b_q_ff <= b_mem[b_raddr];
   end

   always_ff @(posedge clock) begin
      if (g_we) begin
         g_mem[g_waddr] <= g_wdata;
      end
      g_q_ff <= g_mem[g_raddr];
   end

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   // A read response is only raised from the read state.
   a_rsp_from_read: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == mlpbp_pkg::ST_READ))
      else $error("response raised outside the read state");

   // The response register is empty whenever read data is due.
   a_rsp_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mlpbp_pkg::ST_READ) |-> !rsp_valid_ff)
      else $error("read data would overwrite a pending response");

   // Back-propagation products only use next-layer neurons in range.
   a_mac_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mlpbp_pkg::ST_H_MUL) |-> (k_ff < nn))
      else $error("hidden accumulation beyond next-layer size");

   // Finishing a compute marks the results valid.
   a_done_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mlpbp_pkg::ST_W_RD && state_in == mlpbp_pkg::ST_IDLE) |=> ready_ff)
      else $error("compute finished without marking results");

   // A not-yet-computed response carries a zero value.
   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.read_status) |-> (rsp_data_ff.read_value == 16'sd0))
      else $error("status response with non-zero value");

endmodule

`default_nettype wire
